// ===== design/board_row_code_packer_top_assert.svh =====
// assertion macros for the board row code packer
`ifndef BOARD_ROW_CODE_PACKER_TOP_ASSERT_SVH
`define BOARD_ROW_CODE_PACKER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// condition that must hold at every clock edge out of reset
`define BPK_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("bpk assertion failed");
// condition that must never hold
`define BPK_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("bpk forbidden condition seen");
`else
`define BPK_ASSERT(lbl, cond)
`define BPK_NEVER(lbl, cond)
`endif

`endif

// ===== design/bpk_pkg.sv =====
package bpk_pkg;

	// square codes
	localparam logic [1:0] SQ_EMPTY = 2'd0;
	localparam logic [1:0] SQ_X     = 2'd1;
	localparam logic [1:0] SQ_O     = 2'd2;

	localparam int RowCodeW   = 5;
	localparam int BoardCodeW = 3 * RowCodeW;
	localparam int PendW      = 7;
	localparam int ByteBufW   = 24;

	// special row codes
	localparam logic [RowCodeW-1:0] ROW_EMPTY_CODE = 5'b10001;
	localparam logic [2:0]          FULL_LOW_BITS  = 3'b111;
	localparam logic [1:0]          NO_COLUMN      = 2'd3;

	// bytes handed from the merge stage to the output stage
	typedef struct packed {
		logic [ByteBufW-1:0] data;
		logic [1:0]          cnt;
		logic                fin;
	} load_t;

endpackage

// ===== design/bpk_if.sv =====
// board channel
interface bpk_board_if;
	logic       valid;
	logic       ready;
	logic [1:0] sq_r0_c0;
	logic [1:0] sq_r0_c1;
	logic [1:0] sq_r0_c2;
	logic [1:0] sq_r1_c0;
	logic [1:0] sq_r1_c1;
	logic [1:0] sq_r1_c2;
	logic [1:0] sq_r2_c0;
	logic [1:0] sq_r2_c1;
	logic [1:0] sq_r2_c2;
	logic       final_board;

	modport source (
		output valid, sq_r0_c0, sq_r0_c1, sq_r0_c2, sq_r1_c0, sq_r1_c1, sq_r1_c2,
		       sq_r2_c0, sq_r2_c1, sq_r2_c2, final_board,
		input  ready
	);
	modport sink (
		input  valid, sq_r0_c0, sq_r0_c1, sq_r0_c2, sq_r1_c0, sq_r1_c1, sq_r1_c2,
		       sq_r2_c0, sq_r2_c1, sq_r2_c2, final_board,
		output ready
	);
endinterface

// byte channel
interface bpk_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] packed_byte;
	logic       run_last;
	logic       stream_end;

	modport source (output valid, packed_byte, run_last, stream_end, input ready);
	modport sink (input valid, packed_byte, run_last, stream_end, output ready);
endinterface

// ===== design/bpk_row_lane.sv =====
module bpk_row_lane (
	input  logic [2:0][1:0] sq,
	output logic [4:0]      code
);
	import bpk_pkg::*;

	logic [1:0] used;
	logic [2:0] meta;
	logic [2:0] occ;
	logic [1:0] ocnt;
	logic [1:0] xlast;
	logic [1:0] olast;

	// scan the three squares left to right
	always_comb begin
		used  = 2'd0;
		meta  = 3'd0;
		occ   = 3'd0;
		ocnt  = 2'd0;
		xlast = NO_COLUMN;
		olast = NO_COLUMN;
		for (int i = 0; i < 3; i++) begin
			if (sq[i] == SQ_X) begin
				meta[used] = 1'b1;
				xlast      = 2'(i);
			end
			if (sq[i] == SQ_O) begin
				ocnt  = ocnt + 2'd1;
				olast = 2'(i);
			end
			if (sq[i] != SQ_EMPTY) begin
				occ[i] = 1'b1;
				used   = used + 2'd1;
			end
		end
	end

	// pick the code form
	always_comb begin
		if (occ == 3'b000) begin
			code = ROW_EMPTY_CODE;
		end else if (occ == 3'b111) begin
			if (ocnt <= 2'd1) begin
				code = {olast, FULL_LOW_BITS};
			end else begin
				code = {xlast, 3'b000};
			end
		end else begin
			code = {meta[1:0], occ};
		end
	end
endmodule

// ===== design/bpk_merge.sv =====
module bpk_merge (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       take,
	input  logic [bpk_pkg::BoardCodeW-1:0] board_code,
	input  logic                       fin,
	output bpk_pkg::load_t             ld
);
	import bpk_pkg::*;

	logic [PendW-1:0]    pend_q;
	logic [2:0]          pcnt_q;
	logic [ByteBufW-1:0] acc;
	logic                one_full;
	logic [2:0]          left;
	logic [PendW-1:0]    pend_nxt;
	logic [2:0]          pcnt_nxt;

	// append the board code above the pending bits
	always_comb begin
		acc      = {{(ByteBufW-PendW){1'b0}}, pend_q}
		         | ({{(ByteBufW-BoardCodeW){1'b0}}, board_code} << pcnt_q);
		one_full = (pcnt_q == 3'd0);
		left     = one_full ? 3'd7 : (pcnt_q - 3'd1);
		ld.data  = acc;
		ld.cnt   = (one_full ? 2'd1 : 2'd2) + {1'b0, (fin && (left != 3'd0))};
		ld.fin   = fin;
		if (fin) begin
			pend_nxt = '0;
			pcnt_nxt = 3'd0;
		end else if (one_full) begin
			pend_nxt = acc[14:8];
			pcnt_nxt = left;
		end else begin
			pend_nxt = acc[22:16];
			pcnt_nxt = left;
		end
	end

	// bit accumulator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			pcnt_q <= 3'd0;
		end else if (take) begin
			pend_q <= pend_nxt;
			pcnt_q <= pcnt_nxt;
		end
	end
endmodule

// ===== design/bpk_emit.sv =====
module bpk_emit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  bpk_pkg::load_t ld,
	output logic           can_load,
	bpk_byte_if.source     stream
);
	import bpk_pkg::*;

	logic [ByteBufW-1:0] buf_q;
	logic [1:0]          cnt_q;
	logic                fin_q;
	logic                last;

	assign last     = (cnt_q == 2'd1);
	assign can_load = (cnt_q == 2'd0) || (last && stream.ready);

	// output side
	assign stream.valid       = (cnt_q != 2'd0);
	assign stream.packed_byte = buf_q[7:0];
	assign stream.run_last    = last;
	assign stream.stream_end  = last && fin_q;

	// byte count and flush flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			fin_q <= 1'b0;
		end else if (load) begin
			cnt_q <= ld.cnt;
			fin_q <= ld.fin;
		end else if (stream.valid && stream.ready) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// byte shift register
	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= ld.data;
		end else if (stream.valid && stream.ready) begin
			buf_q <= {8'd0, buf_q[ByteBufW-1:8]};
		end
	end
endmodule

// ===== design/board_row_code_packer_top.sv =====
// path: an accepted board is registered in the input stage, then loaded into the byte buffer
// throughput: one byte per cycle from the output shift register while the receiver is ready;
// a board gives one or two bytes, three when a final board flushes a partial byte, and the
// single-byte output port limits how fast boards are taken
// reset: asynchronous active-low arst_n empties the input stage, the byte buffer and
// the bit accumulator
`include "board_row_code_packer_top_assert.svh"

module board_row_code_packer_top (
	input  logic        clk,
	input  logic        arst_n,
	bpk_board_if.sink   board,
	bpk_byte_if.source  stream
);
	import bpk_pkg::*;

	logic [2:0][2:0][1:0]    sq_s1;
	logic                    fin_s1;
	logic                    valid_s1;
	logic                    can_load;
	logic                    take;
	logic [2:0][RowCodeW-1:0] row_code;
	load_t                   ld;

	assign take        = valid_s1 && can_load;
	assign board.ready = !valid_s1 || can_load;

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (board.ready) begin
			valid_s1 <= board.valid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (board.valid && board.ready) begin
			sq_s1[0][0] <= board.sq_r0_c0;
			sq_s1[0][1] <= board.sq_r0_c1;
			sq_s1[0][2] <= board.sq_r0_c2;
			sq_s1[1][0] <= board.sq_r1_c0;
			sq_s1[1][1] <= board.sq_r1_c1;
			sq_s1[1][2] <= board.sq_r1_c2;
			sq_s1[2][0] <= board.sq_r2_c0;
			sq_s1[2][1] <= board.sq_r2_c1;
			sq_s1[2][2] <= board.sq_r2_c2;
			fin_s1      <= board.final_board;
		end
	end

	// one row coder per row
	for (genvar r = 0; r < 3; r++) begin : g_lane
		bpk_row_lane u_lane (
			.sq   (sq_s1[r]),
			.code (row_code[r])
		);
	end

	// join the rows and pack into bytes
	bpk_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.board_code (row_code),
		.fin        (fin_s1),
		.ld         (ld)
	);

	// byte output stage
	bpk_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (take),
		.ld       (ld),
		.can_load (can_load),
		.stream   (stream)
	);

	// checks
	`BPK_ASSERT(a_end_is_last, !(stream.valid && stream.stream_end) || stream.run_last)
	`BPK_ASSERT(a_load_shows_byte, !$past(take) || stream.valid)
	`BPK_NEVER(a_item_dropped, $past(valid_s1 && !can_load) && !valid_s1)
endmodule

// ===== dv/board_row_code_packer_top_test.sv =====
`timescale 1ns / 1ps

module board_row_code_packer_top_test;
	import bpk_pkg::*;

	// square value outside the three legal codes
	localparam logic [1:0] SQ_ODD = 2'd3;

	typedef logic [0:2][1:0] row_t;

	typedef struct packed {
		logic [0:8][1:0] sq;
		logic            fin;
	} board_t;

	typedef struct packed {
		logic [7:0] data;
		logic       run_last;
		logic       stream_end;
	} out_byte_t;

	logic clk;
	logic arst_n;

	bpk_board_if board_ch ();
	bpk_byte_if  byte_ch ();

	board_row_code_packer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.board  (board_ch),
		.stream (byte_ch)
	);

	// bytes predicted but not yet seen on the output
	out_byte_t due_bytes[$];
	// bit accumulator of the predictor
	logic [6:0] pend_bits;
	logic [2:0] pend_cnt;

	int mismatches;
	bit idle_on;
	int hold_req;

	// clock
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// run limit
	initial begin
		#2_000_000;
		$display("board_row_code_packer_top: mismatch");
		$finish;
	end

	// 5-bit code of one row
	function automatic logic [4:0] row_word(row_t r);
		logic [2:0] occ;
		logic [1:0] flags;
		logic [1:0] xcol;
		logic [1:0] ocol;
		int used;
		int ocnt;
		occ = '0;
		flags = '0;
		xcol = NO_COLUMN;
		ocol = NO_COLUMN;
		used = 0;
		ocnt = 0;
		for (int i = 0; i < 3; i++) begin
			if (r[i] == SQ_X) begin
				if (used < 2)
					flags[used] = 1'b1;
				xcol = 2'(i);
			end
			if (r[i] == SQ_O) begin
				ocnt++;
				ocol = 2'(i);
			end
			if (r[i] != SQ_EMPTY) begin
				occ[i] = 1'b1;
				used++;
			end
		end
		if (used == 0)
			return ROW_EMPTY_CODE;
		if (used == 3) begin
			if (ocnt <= 1)
				return {ocol, FULL_LOW_BITS};
			return {xcol, 3'b000};
		end
		return {flags, occ};
	endfunction

	// append one board code to the accumulator and queue the bytes it completes
	function automatic void pack_board(board_t b);
		logic [14:0] code;
		logic [31:0] acc;
		out_byte_t outs[3];
		int total;
		int n;
		code = {row_word(b.sq[6:8]), row_word(b.sq[3:5]), row_word(b.sq[0:2])};
		acc = 32'(pend_bits) | (32'(code) << pend_cnt);
		total = int'(pend_cnt) + BoardCodeW;
		n = 0;
		while (total >= 8) begin
			outs[n] = '{data: acc[7:0], run_last: 1'b0, stream_end: 1'b0};
			n++;
			acc = acc >> 8;
			total -= 8;
		end
		// flush of the partial byte, zero padded
		if (b.fin && total > 0) begin
			outs[n] = '{data: acc[7:0], run_last: 1'b0, stream_end: 1'b0};
			n++;
			total = 0;
		end
		outs[n-1].run_last = 1'b1;
		outs[n-1].stream_end = b.fin;
		for (int i = 0; i < n; i++)
			due_bytes.insert(due_bytes.size(), outs[i]);
		if (b.fin) begin
			pend_bits = '0;
			pend_cnt = '0;
		end else begin
			pend_bits = acc[6:0];
			pend_cnt = 3'(total);
		end
	endfunction

	function automatic row_t mk_row(logic [1:0] c0, logic [1:0] c1, logic [1:0] c2);
		return {c0, c1, c2};
	endfunction

	function automatic board_t mk_board(row_t r0, row_t r1, row_t r2, logic fin);
		board_t b;
		b.sq = {r0, r1, r2};
		b.fin = fin;
		return b;
	endfunction

	function automatic logic [1:0] rand_square(bit full);
		int v;
		v = full ? $urandom_range(3, 9) : $urandom_range(0, 9);
		if (v < 3)
			return SQ_EMPTY;
		if (v < 6)
			return SQ_X;
		if (v < 9)
			return SQ_O;
		return SQ_ODD;
	endfunction

	// rows are often full so the special full-row codes come up a lot
	function automatic board_t rand_board();
		board_t b;
		bit full;
		for (int r = 0; r < 3; r++) begin
			full = ($urandom_range(0, 2) == 0);
			for (int c = 0; c < 3; c++)
				b.sq[r*3+c] = rand_square(full);
		end
		b.fin = ($urandom_range(0, 7) == 0);
		return b;
	endfunction

	// idle length: mostly short, a few long
	function automatic int idle_len();
		if ($urandom_range(0, 15) < 12)
			return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	function automatic int gap_len();
		if (!idle_on || $urandom_range(0, 1) == 0)
			return 0;
		return idle_len();
	endfunction

	// offer one board, wait for it to be taken, then maybe idle
	task automatic send_board(board_t b);
		int gap;
		board_ch.valid       <= 1'b1;
		board_ch.sq_r0_c0    <= b.sq[0];
		board_ch.sq_r0_c1    <= b.sq[1];
		board_ch.sq_r0_c2    <= b.sq[2];
		board_ch.sq_r1_c0    <= b.sq[3];
		board_ch.sq_r1_c1    <= b.sq[4];
		board_ch.sq_r1_c2    <= b.sq[5];
		board_ch.sq_r2_c0    <= b.sq[6];
		board_ch.sq_r2_c1    <= b.sq[7];
		board_ch.sq_r2_c2    <= b.sq[8];
		board_ch.final_board <= b.fin;
		do
			@(posedge clk);
		while (!board_ch.ready);
		pack_board(b);
		gap = gap_len();
		if (gap > 0) begin
			board_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop offering and wait until every predicted byte has come out
	task automatic drain();
		board_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (due_bytes.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// every row code case; the eighth board is final with one bit pending,
	// so the flush finds nothing left and no padding byte is sent
	task automatic test_row_codes();
		send_board(mk_board(mk_row(SQ_EMPTY, SQ_EMPTY, SQ_EMPTY),
			mk_row(SQ_EMPTY, SQ_EMPTY, SQ_EMPTY), mk_row(SQ_EMPTY, SQ_EMPTY, SQ_EMPTY), 1'b0));
		send_board(mk_board(mk_row(SQ_X, SQ_X, SQ_X),
			mk_row(SQ_O, SQ_O, SQ_O), mk_row(SQ_EMPTY, SQ_EMPTY, SQ_EMPTY), 1'b0));
		send_board(mk_board(mk_row(SQ_O, SQ_X, SQ_X),
			mk_row(SQ_X, SQ_O, SQ_X), mk_row(SQ_X, SQ_X, SQ_O), 1'b0));
		send_board(mk_board(mk_row(SQ_X, SQ_O, SQ_O),
			mk_row(SQ_O, SQ_X, SQ_O), mk_row(SQ_O, SQ_O, SQ_X), 1'b0));
		send_board(mk_board(mk_row(SQ_X, SQ_EMPTY, SQ_EMPTY),
			mk_row(SQ_EMPTY, SQ_O, SQ_EMPTY), mk_row(SQ_EMPTY, SQ_EMPTY, SQ_X), 1'b0));
		send_board(mk_board(mk_row(SQ_X, SQ_O, SQ_EMPTY),
			mk_row(SQ_X, SQ_EMPTY, SQ_O), mk_row(SQ_EMPTY, SQ_X, SQ_X), 1'b0));
		// odd square value in full rows
		send_board(mk_board(mk_row(SQ_ODD, SQ_ODD, SQ_ODD),
			mk_row(SQ_ODD, SQ_X, SQ_O), mk_row(SQ_O, SQ_O, SQ_ODD), 1'b0));
		// odd square value in partial rows
		send_board(mk_board(mk_row(SQ_ODD, SQ_EMPTY, SQ_EMPTY),
			mk_row(SQ_EMPTY, SQ_ODD, SQ_X), mk_row(SQ_X, SQ_EMPTY, SQ_ODD), 1'b1));
	endtask

	// flush from an empty accumulator, the three-byte case, extreme boards
	task automatic test_flush_cases();
		send_board(mk_board(mk_row(SQ_O, SQ_O, SQ_O),
			mk_row(SQ_O, SQ_O, SQ_O), mk_row(SQ_O, SQ_O, SQ_O), 1'b1));
		send_board(mk_board(mk_row(SQ_X, SQ_X, SQ_X),
			mk_row(SQ_X, SQ_X, SQ_X), mk_row(SQ_X, SQ_X, SQ_X), 1'b0));
		send_board(mk_board(mk_row(SQ_ODD, SQ_ODD, SQ_ODD),
			mk_row(SQ_ODD, SQ_ODD, SQ_ODD), mk_row(SQ_ODD, SQ_ODD, SQ_ODD), 1'b1));
		send_board(mk_board(mk_row(SQ_EMPTY, SQ_X, SQ_EMPTY),
			mk_row(SQ_O, SQ_EMPTY, SQ_O), mk_row(SQ_EMPTY, SQ_EMPTY, SQ_O), 1'b0));
		send_board(mk_board(mk_row(SQ_O, SQ_X, SQ_EMPTY),
			mk_row(SQ_EMPTY, SQ_O, SQ_X), mk_row(SQ_X, SQ_O, SQ_X), 1'b1));
	endtask

	// long receiver hold while boards keep coming back to back
	task automatic test_backpressure();
		bit saved;
		saved = idle_on;
		idle_on = 1'b0;
		hold_req = 60;
		for (int i = 0; i < 14; i++)
			send_board(rand_board());
		idle_on = saved;
	endtask

	// sender stops until the output has caught up, then resumes
	task automatic test_sender_pause();
		for (int i = 0; i < 6; i++)
			send_board(rand_board());
		drain();
		for (int i = 0; i < 6; i++)
			send_board(rand_board());
	endtask

	task automatic test_random();
		board_t b;
		for (int i = 0; i < 330; i++) begin
			if (i % 40 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			send_board(rand_board());
		end
		b = rand_board();
		b.fin = 1'b1;
		send_board(b);
	endtask

	// output side: random stalls plus the requested long hold
	initial begin
		int hold_left;
		int stall_left;
		hold_left = 0;
		stall_left = 0;
		byte_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				byte_ch.ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				byte_ch.ready <= 1'b0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				byte_ch.ready <= 1'b0;
				stall_left = idle_len() - 1;
			end else begin
				byte_ch.ready <= 1'b1;
			end
		end
	end

	// compare each byte taken with the oldest prediction
	always @(posedge clk) begin
		out_byte_t want;
		if (arst_n && byte_ch.valid && byte_ch.ready) begin
			if (due_bytes.size() == 0) begin
				$error("packed_byte: expected none, got %02h", byte_ch.packed_byte);
				mismatches++;
			end else begin
				want = due_bytes.pop_front();
				if (byte_ch.packed_byte !== want.data) begin
					$error("packed_byte: expected %02h, got %02h", want.data,
						byte_ch.packed_byte);
					mismatches++;
				end
				if (byte_ch.run_last !== want.run_last) begin
					$error("run_last: expected %0b, got %0b", want.run_last,
						byte_ch.run_last);
					mismatches++;
				end
				if (byte_ch.stream_end !== want.stream_end) begin
					$error("stream_end: expected %0b, got %0b", want.stream_end,
						byte_ch.stream_end);
					mismatches++;
				end
			end
		end
	end

	initial begin
		mismatches = 0;
		idle_on = 1'b1;
		hold_req = 0;
		pend_bits = '0;
		pend_cnt = '0;
		arst_n               <= 1'b0;
		board_ch.valid       <= 1'b0;
		board_ch.sq_r0_c0    <= SQ_EMPTY;
		board_ch.sq_r0_c1    <= SQ_EMPTY;
		board_ch.sq_r0_c2    <= SQ_EMPTY;
		board_ch.sq_r1_c0    <= SQ_EMPTY;
		board_ch.sq_r1_c1    <= SQ_EMPTY;
		board_ch.sq_r1_c2    <= SQ_EMPTY;
		board_ch.sq_r2_c0    <= SQ_EMPTY;
		board_ch.sq_r2_c1    <= SQ_EMPTY;
		board_ch.sq_r2_c2    <= SQ_EMPTY;
		board_ch.final_board <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_row_codes();
		test_flush_cases();
		test_backpressure();
		test_sender_pause();
		test_random();

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && due_bytes.size() == 0)
			$display("board_row_code_packer_top: match");
		else
			$display("board_row_code_packer_top: mismatch");
		$finish;
	end

endmodule
